// File: src/frr_pkg.sv
// ----------------------------------------------------------------------------
// frr_pkg
// shared types, codes and register indexes of the framed request receiver
// ----------------------------------------------------------------------------
package frr_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_START_ONE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_TWO     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_THREE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_FOUR    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWEST_ID     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LIMIT = 3'd5;

  localparam logic [15:0] PAYLOAD_LIMIT_RESET = 16'd1024;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PAYLOAD = 2'd1;
  localparam logic [1:0] EV_ACCEPT  = 2'd2;
  localparam logic [1:0] EV_DROP    = 2'd3;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_GAP  = 1'b1;

  typedef struct packed {
    logic [7:0]  start_byte_one;
    logic [7:0]  start_byte_two;
    logic [7:0]  start_byte_three;
    logic [7:0]  start_byte_four;
    logic [7:0]  lowest_id;
    logic [15:0] payload_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic [7:0]  request_id;
    logic [15:0] payload_length;
  } result_t;

endpackage

// File: src/frr_cfg_regs.sv
// ----------------------------------------------------------------------------
// frr_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module frr_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [frr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [frr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output frr_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte_one   <= 8'd0;
      cfg.start_byte_two   <= 8'd0;
      cfg.start_byte_three <= 8'd0;
      cfg.start_byte_four  <= 8'd0;
      cfg.lowest_id        <= 8'd0;
      cfg.payload_limit    <= frr_pkg::PAYLOAD_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        frr_pkg::REG_START_ONE:     cfg.start_byte_one   <= cfg_data[7:0];
        frr_pkg::REG_START_TWO:     cfg.start_byte_two   <= cfg_data[7:0];
        frr_pkg::REG_START_THREE:   cfg.start_byte_three <= cfg_data[7:0];
        frr_pkg::REG_START_FOUR:    cfg.start_byte_four  <= cfg_data[7:0];
        frr_pkg::REG_LOWEST_ID:     cfg.lowest_id        <= cfg_data[7:0];
        frr_pkg::REG_PAYLOAD_LIMIT: cfg.payload_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: src/frr_core.sv
// ----------------------------------------------------------------------------
// frr_core
// frame state machine, checksum and per-beat result
// ----------------------------------------------------------------------------
module frr_core (
  input  logic              clk,
  input  logic              rst,
  input  frr_pkg::cfg_t     cfg,
  input  logic              beat,
  input  logic              command,
  input  logic [7:0]        rx_byte,
  output frr_pkg::result_t  result
);

  typedef enum logic [3:0] {
    SOF1    = 4'd0,
    SOF2    = 4'd1,
    SOF3    = 4'd2,
    SOF4    = 4'd3,
    ID      = 4'd4,
    LEN1    = 4'd5,
    LEN2    = 4'd6,
    PAYLOAD = 4'd7,
    CRC1    = 4'd8,
    CRC2    = 4'd9
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] byte_counter, byte_counter_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  checksum_low_byte, checksum_low_byte_next;
  logic [7:0]  held_id, held_id_next;
  logic [15:0] held_length, held_length_next;

  logic [15:0] sum_add;
  logic [15:0] sum_shift;
  logic [15:0] count_inc;
  logic [15:0] len_full;
  logic [7:0]  want;
  logic        drop;

  assign sum_add   = running_sum + {8'd0, rx_byte};
  assign sum_shift = {sum_add[14:0], 1'b0};
  assign count_inc = byte_counter + 16'd1;
  assign len_full  = {rx_byte, held_length[7:0]};

  always_comb begin
    case (phase)
      SOF1:    want = cfg.start_byte_one;
      SOF2:    want = cfg.start_byte_two;
      SOF3:    want = cfg.start_byte_three;
      default: want = cfg.start_byte_four;
    endcase
  end

  always_comb begin
    phase_next             = phase;
    byte_counter_next      = byte_counter;
    running_sum_next       = running_sum;
    checksum_low_byte_next = checksum_low_byte;
    held_id_next           = held_id;
    held_length_next       = held_length;
    result                 = '0;
    drop                   = 1'b0;

    if (command == frr_pkg::CMD_GAP) begin
      drop = 1'b1;
    end else begin
      case (phase)
        SOF1, SOF2, SOF3, SOF4: begin
          if (rx_byte == want) begin
            running_sum_next  = sum_shift;
            phase_next        = phase_t'(phase + 4'd1);
            byte_counter_next = count_inc;
          end else begin
            drop = 1'b1;
          end
        end
        ID: begin
          if (rx_byte > cfg.lowest_id) begin
            running_sum_next = sum_shift;
            held_id_next     = rx_byte;
            phase_next       = LEN1;
          end else begin
            drop = 1'b1;
          end
        end
        LEN1: begin
          running_sum_next = sum_shift;
          held_length_next = {8'd0, rx_byte};
          phase_next       = LEN2;
        end
        LEN2: begin
          held_length_next = len_full;
          if (len_full == 16'd0) begin
            running_sum_next = sum_shift;
            phase_next       = CRC1;
          end else if (len_full <= cfg.payload_limit) begin
            running_sum_next  = sum_shift;
            phase_next        = PAYLOAD;
            byte_counter_next = 16'd0;
          end else begin
            drop = 1'b1;
          end
        end
        PAYLOAD: begin
          running_sum_next     = sum_shift;
          result.event_res     = frr_pkg::EV_PAYLOAD;
          result.payload_index = byte_counter;
          result.payload_byte  = rx_byte;
          byte_counter_next    = count_inc;
          if (count_inc == held_length) begin
            phase_next = CRC1;
          end
        end
        CRC1: begin
          checksum_low_byte_next = rx_byte;
          phase_next             = CRC2;
        end
        CRC2: begin
          if ({rx_byte, checksum_low_byte} == running_sum) begin
            result.event_res      = frr_pkg::EV_ACCEPT;
            result.request_id     = held_id;
            result.payload_length = held_length;
            phase_next             = SOF1;
            byte_counter_next      = 16'd0;
            running_sum_next       = 16'd0;
            checksum_low_byte_next = 8'd0;
            held_id_next           = 8'd0;
            held_length_next       = 16'd0;
          end else begin
            drop = 1'b1;
          end
        end
        default: drop = 1'b1;
      endcase
    end

    if (drop) begin
      result                 = '0;
      result.event_res       = (phase == SOF1) ? frr_pkg::EV_NONE : frr_pkg::EV_DROP;
      phase_next             = SOF1;
      byte_counter_next      = 16'd0;
      running_sum_next       = 16'd0;
      checksum_low_byte_next = 8'd0;
      held_id_next           = 8'd0;
      held_length_next       = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= SOF1;
      byte_counter      <= 16'd0;
      running_sum       <= 16'd0;
      checksum_low_byte <= 8'd0;
      held_id           <= 8'd0;
      held_length       <= 16'd0;
    end else if (beat) begin
      phase             <= phase_next;
      byte_counter      <= byte_counter_next;
      running_sum       <= running_sum_next;
      checksum_low_byte <= checksum_low_byte_next;
      held_id           <= held_id_next;
      held_length       <= held_length_next;
    end
  end

endmodule

// File: src/frr_out_reg.sv
// ----------------------------------------------------------------------------
// frr_out_reg
// result register on the master side, loads while empty or draining
// ----------------------------------------------------------------------------
module frr_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  frr_pkg::result_t  result,
  output logic              in_ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,
  output logic [1:0]        m_tuser
);

  assign in_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {result.payload_length, result.request_id,
                  result.payload_byte, result.payload_index};
      m_tuser <= result.event_res;
    end
  end

endmodule

// File: src/framed_request_receiver.sv
// ----------------------------------------------------------------------------
// framed_request_receiver
// byte-serial deframer for length-prefixed frames with a shift-add checksum
// ----------------------------------------------------------------------------
// timing: an accepted input beat gives its result beat in the next cycle
// throughput: one byte per cycle, one result beat for every input beat
// rate is set by the single result register; s_tready drops only while it is
// full and m_tready is low
// reset: synchronous, clears frame state and loads register defaults
// ----------------------------------------------------------------------------
module framed_request_receiver (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // rx_byte
  input  logic [0:0]                      s_tuser,   // command
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [47:0]                     m_tdata,   // payload_index, payload_byte,
                                                     // request_id, payload_length
  output logic [1:0]                      m_tuser,   // event_res
  input  logic                            cfg_we,
  input  logic [frr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [frr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  frr_pkg::cfg_t    cfg;
  frr_pkg::result_t result;
  logic             beat;

  assign beat = s_tvalid && s_tready;

  frr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  frr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .beat    (beat),
    .command (s_tuser[0]),
    .rx_byte (s_tdata),
    .result  (result)
  );

  frr_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (beat),
    .result   (result),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: src/frr_checker.sv
// ----------------------------------------------------------------------------
// frr_checker
// port-level checks of the framed request receiver
// ----------------------------------------------------------------------------
module frr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted beat gave no result");

  a_gap_event: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] == frr_pkg::CMD_GAP |=>
      m_tuser == frr_pkg::EV_NONE || m_tuser == frr_pkg::EV_DROP)
    else $error("gap beat gave payload or accept event");

  a_payload_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == frr_pkg::EV_PAYLOAD |-> m_tdata[47:24] == 24'd0)
    else $error("payload event carries frame fields");

endmodule

bind framed_request_receiver frr_checker u_frr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: test/framed_request_receiver_test.sv
// ----------------------------------------------------------------------------
// framed_request_receiver_test
// self-checking bench: byte beats go in on the slave stream, every result beat
// is compared against a frame-tracking scoreboard that mirrors the deframer's
// phases, running checksum and registers; directed frames first, then random
// frames, broken frames and noise under several register settings
// ----------------------------------------------------------------------------
module framed_request_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [frr_pkg::CFG_INDEX_W-1:0] REG_UNUSED_FIRST = 3'd6;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;

  typedef enum logic [3:0] {
    PH_START1, PH_START2, PH_START3, PH_START4, PH_ID,
    PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_SUM_LO, PH_SUM_HI
  } frame_phase_e;

  typedef enum int {
    FLAW_NONE, FLAW_START, FLAW_ID, FLAW_OVERSIZE, FLAW_SUM, FLAW_GAP
  } frame_flaw_e;

  class frame_scoreboard;
    frr_pkg::cfg_t    regs;
    frame_phase_e     phase;
    logic [15:0]      byte_count;
    logic [15:0]      run_sum;
    logic [7:0]       sum_lo;
    logic [7:0]       held_id;
    logic [15:0]      held_len;
    frr_pkg::result_t expected_q[$];
    int               mismatches;
    int               checked;
    int               payload_beats;
    int               frames_accepted;
    int               frames_dropped;

    function void restart_frame();
      phase      = PH_START1;
      byte_count = '0;
      run_sum    = '0;
      sum_lo     = '0;
      held_id    = '0;
      held_len   = '0;
    endfunction

    function void reset_block();
      regs = '0;
      regs.payload_limit = frr_pkg::PAYLOAD_LIMIT_RESET;
      restart_frame();
      expected_q.delete();
    endfunction

    function void write_reg(logic [frr_pkg::CFG_INDEX_W-1:0] idx,
                            logic [frr_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        frr_pkg::REG_START_ONE:     regs.start_byte_one   = data[7:0];
        frr_pkg::REG_START_TWO:     regs.start_byte_two   = data[7:0];
        frr_pkg::REG_START_THREE:   regs.start_byte_three = data[7:0];
        frr_pkg::REG_START_FOUR:    regs.start_byte_four  = data[7:0];
        frr_pkg::REG_LOWEST_ID:     regs.lowest_id        = data[7:0];
        frr_pkg::REG_PAYLOAD_LIMIT: regs.payload_limit    = data[15:0];
        default: ;
      endcase
    endfunction

    function void add_sum(logic [7:0] b);
      run_sum = (run_sum + {8'h00, b}) << 1;
    endfunction

    function void note_beat(logic cmd, logic [7:0] b);
      frr_pkg::result_t r;
      logic             drop;
      logic [7:0]       want;
      r    = '0;
      drop = 1'b0;
      want = '0;
      if (cmd == frr_pkg::CMD_GAP) begin
        drop = 1'b1;
      end else begin
        case (phase)
          PH_START1, PH_START2, PH_START3, PH_START4: begin
            case (phase)
              PH_START1: want = regs.start_byte_one;
              PH_START2: want = regs.start_byte_two;
              PH_START3: want = regs.start_byte_three;
              default:   want = regs.start_byte_four;
            endcase
            if (b == want) begin
              add_sum(b);
              phase      = frame_phase_e'(phase + 4'd1);
              byte_count = byte_count + 16'd1;
            end else begin
              drop = 1'b1;
            end
          end
          PH_ID: begin
            if (b > regs.lowest_id) begin
              add_sum(b);
              held_id = b;
              phase   = PH_LEN_LO;
            end else begin
              drop = 1'b1;
            end
          end
          PH_LEN_LO: begin
            add_sum(b);
            held_len = {8'h00, b};
            phase    = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            held_len[15:8] = b;
            if (held_len == 16'd0) begin
              add_sum(b);
              phase = PH_SUM_LO;
            end else if (held_len <= regs.payload_limit) begin
              add_sum(b);
              phase      = PH_PAYLOAD;
              byte_count = '0;
            end else begin
              drop = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            add_sum(b);
            r.event_res     = frr_pkg::EV_PAYLOAD;
            r.payload_index = byte_count;
            r.payload_byte  = b;
            byte_count      = byte_count + 16'd1;
            if (byte_count == held_len) phase = PH_SUM_LO;
            payload_beats++;
          end
          PH_SUM_LO: begin
            sum_lo = b;
            phase  = PH_SUM_HI;
          end
          PH_SUM_HI: begin
            if ({b, sum_lo} == run_sum) begin
              r.event_res      = frr_pkg::EV_ACCEPT;
              r.request_id     = held_id;
              r.payload_length = held_len;
              frames_accepted++;
              restart_frame();
            end else begin
              drop = 1'b1;
            end
          end
          default: drop = 1'b1;
        endcase
      end
      if (drop) begin
        r = '0;
        r.event_res = (phase == PH_START1) ? frr_pkg::EV_NONE : frr_pkg::EV_DROP;
        if (phase != PH_START1) frames_dropped++;
        restart_frame();
      end
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 100) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(logic [1:0] tuser, logic [47:0] tdata);
      frr_pkg::result_t got;
      frr_pkg::result_t want;
      got.event_res      = tuser;
      got.payload_index  = tdata[15:0];
      got.payload_byte   = tdata[23:16];
      got.request_id     = tdata[31:24];
      got.payload_length = tdata[47:32];
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected, event %0d", tuser));
      end else begin
        want = expected_q.pop_front();
        if (got.event_res !== want.event_res)
          report_mismatch($sformatf("beat %0d event got %0d want %0d",
                                    checked, got.event_res, want.event_res));
        if (got.payload_index !== want.payload_index)
          report_mismatch($sformatf("beat %0d payload_index got %0d want %0d",
                                    checked, got.payload_index, want.payload_index));
        if (got.payload_byte !== want.payload_byte)
          report_mismatch($sformatf("beat %0d payload_byte got %h want %h",
                                    checked, got.payload_byte, want.payload_byte));
        if (got.request_id !== want.request_id)
          report_mismatch($sformatf("beat %0d request_id got %h want %h",
                                    checked, got.request_id, want.request_id));
        if (got.payload_length !== want.payload_length)
          report_mismatch($sformatf("beat %0d payload_length got %0d want %0d",
                                    checked, got.payload_length, want.payload_length));
      end
      checked++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [7:0]                      s_tdata   = '0;  // rx_byte
  logic [0:0]                      s_tuser   = '0;  // command
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [47:0]                     m_tdata;         // payload_index, payload_byte,
                                                    // request_id, payload_length
  logic [1:0]                      m_tuser;         // event_res
  logic                            cfg_we    = 1'b0;
  logic [frr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [frr_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  frame_scoreboard sb;
  frr_pkg::cfg_t   cur_cfg;
  int              items_sent   = 0;
  int              settings_run = 0;
  int              stall_cycles = 0;
  bit              no_idle      = 1'b0;
  bit              hold_request = 1'b0;

  always #1 clk = ~clk;

  framed_request_receiver i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 80) return $urandom_range(1, 12);
    if (r < 97) return $urandom_range(13, 64);
    return $urandom_range(100, 400);
  endfunction

  function automatic frr_pkg::cfg_t phase_settings(int k);
    frr_pkg::cfg_t c;
    c.start_byte_one   = 8'($urandom);
    c.start_byte_two   = 8'($urandom);
    c.start_byte_three = 8'($urandom);
    c.start_byte_four  = 8'($urandom);
    c.lowest_id        = 8'($urandom_range(0, 96));
    c.payload_limit    = 16'($urandom_range(1, 40));
    case (k)
      0: begin
        c.start_byte_one   = 8'h00;
        c.start_byte_two   = 8'h00;
        c.start_byte_three = 8'h00;
        c.start_byte_four  = 8'h00;
        c.lowest_id        = 8'h00;
        c.payload_limit    = 16'hffff;
      end
      1: begin
        c.start_byte_one   = 8'hff;
        c.start_byte_two   = 8'hff;
        c.start_byte_three = 8'hff;
        c.start_byte_four  = 8'hff;
        c.lowest_id        = 8'hfe;
        c.payload_limit    = 16'h0000;
      end
      2: c.payload_limit = frr_pkg::PAYLOAD_LIMIT_RESET;
      3: c.lowest_id = 8'hff;
      5: begin
        c.start_byte_two   = c.start_byte_one;
        c.start_byte_three = c.start_byte_one;
        c.start_byte_four  = c.start_byte_one;
      end
      default: ;
    endcase
    return c;
  endfunction

  // only called while nothing is in flight
  task automatic program_regs(input frr_pkg::cfg_t c);
    logic [frr_pkg::CFG_INDEX_W-1:0] ix;
    logic [frr_pkg::CFG_DATA_W-1:0]  dv;
    for (int i = 0; i < 7; i++) begin
      case (i)
        0: begin ix = frr_pkg::REG_START_ONE; dv = {8'($urandom), c.start_byte_one}; end
        1: begin ix = frr_pkg::REG_START_TWO; dv = {8'($urandom), c.start_byte_two}; end
        2: begin
          ix = frr_pkg::REG_START_THREE;
          dv = {8'($urandom), c.start_byte_three};
        end
        3: begin ix = frr_pkg::REG_START_FOUR; dv = {8'($urandom), c.start_byte_four}; end
        4: begin ix = frr_pkg::REG_LOWEST_ID; dv = {8'($urandom), c.lowest_id}; end
        5: begin ix = frr_pkg::REG_PAYLOAD_LIMIT; dv = c.payload_limit; end
        default: begin
          ix = REG_UNUSED_FIRST + frr_pkg::CFG_INDEX_W'($urandom_range(0, 1));
          dv = 16'($urandom);
        end
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= ix;
      cfg_data  <= dv;
      sb.write_reg(ix, dv);
      @(negedge clk);
    end
    cfg_we  <= 1'b0;
    cur_cfg = c;
    settings_run++;
  endtask

  task automatic send_beat(input logic cmd, input logic [7:0] b);
    int g;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
    g = no_idle ? 0 : pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic send_frame(input frame_flaw_e flaw, input logic [7:0] id,
                            input logic [15:0] len);
    logic [7:0]  bytes_q[$];
    logic [15:0] sum;
    int          gap_at;
    int          p;
    gap_at  = -1;
    bytes_q = {cur_cfg.start_byte_one, cur_cfg.start_byte_two, cur_cfg.start_byte_three,
               cur_cfg.start_byte_four, id, len[7:0], len[15:8]};
    if (flaw != FLAW_OVERSIZE) begin
      repeat (len) bytes_q.push_back(8'($urandom));
      sum = '0;
      foreach (bytes_q[i]) sum = (sum + {8'h00, bytes_q[i]}) << 1;
      if (flaw == FLAW_SUM) sum ^= 16'($urandom_range(1, 16'hffff));
      bytes_q.push_back(sum[7:0]);
      bytes_q.push_back(sum[15:8]);
    end
    if (flaw == FLAW_START) begin
      p = $urandom_range(0, 3);
      bytes_q[p] ^= 8'($urandom_range(1, 255));
    end
    if (flaw == FLAW_GAP) gap_at = $urandom_range(0, bytes_q.size() - 1);
    foreach (bytes_q[i])
      send_beat((i == gap_at) ? frr_pkg::CMD_GAP : frr_pkg::CMD_BYTE, bytes_q[i]);
  endtask

  task automatic random_frame(input frame_flaw_e flaw);
    logic [7:0] id;
    int         lim;
    int         n;
    lim     = cur_cfg.payload_limit;
    no_idle = ($urandom_range(0, 5) == 0);
    if (flaw == FLAW_OVERSIZE && lim == 65535) flaw = FLAW_SUM;
    if (flaw == FLAW_ID || cur_cfg.lowest_id == 8'hff)
      id = 8'($urandom_range(0, cur_cfg.lowest_id));
    else
      id = 8'($urandom_range(cur_cfg.lowest_id + 1, 255));
    if (flaw == FLAW_OVERSIZE) begin
      n = $urandom_range(lim + 1, (lim + 300 > 65535) ? 65535 : lim + 300);
    end else begin
      n = pick_length();
      if (n > lim) n = lim;
    end
    send_frame(flaw, id, 16'(n));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
      if (s_tvalid && s_tready) sb.note_beat(s_tuser[0], s_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
    $display("** framed_request_receiver: FAILED **");
    $finish;
  end

  // result side: random ready pattern, one long hold-off on request
  initial begin
    int run;
    int idle;
    wait (rst == 1'b0);
    forever begin
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        run = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
        m_tready <= 1'b1;
        repeat (run) @(negedge clk);
        idle = pick_gap();
        if (idle > 0) begin
          m_tready <= 1'b0;
          repeat (idle) @(negedge clk);
        end
      end
    end
  end

  initial begin
    frr_pkg::cfg_t c;
    int            phase_end;
    int            frames;
    int            r;
    frame_flaw_e   flaw;
    sb = new();
    sb.reset_block();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    c.start_byte_one   = 8'h00;
    c.start_byte_two   = 8'hff;
    c.start_byte_three = 8'h5a;
    c.start_byte_four  = 8'ha5;
    c.lowest_id        = 8'h10;
    c.payload_limit    = 16'd8;
    program_regs(c);
    send_beat(frr_pkg::CMD_GAP, 8'h00);
    send_beat(frr_pkg::CMD_BYTE, 8'hff);
    send_frame(FLAW_NONE, 8'hff, 16'd0);
    send_frame(FLAW_ID, 8'h10, 16'd0);
    send_frame(FLAW_OVERSIZE, 8'h11, 16'd9);
    drain_results();

    for (int k = 0; k < PHASES; k++) begin
      program_regs(phase_settings(k));
      phase_end = items_sent + ((k == 3) ? 80 : 240);
      frames    = 0;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          no_idle = 1'b0;
          repeat ($urandom_range(1, 8))
            send_beat(($urandom_range(0, 7) == 0) ? frr_pkg::CMD_GAP : frr_pkg::CMD_BYTE,
                      8'($urandom));
        end else begin
          flaw = (r < 65) ? FLAW_NONE : frame_flaw_e'($urandom_range(1, 5));
          random_frame(flaw);
        end
        frames++;
        if (k == 2 && frames == 4) hold_request = 1'b1;
        if (k == 4 && frames == 4) drain_results();
      end
      drain_results();
    end

    repeat (10) @(negedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
    $display("covered %0d input beats over %0d register settings, with a %0d-cycle hold-off",
             items_sent, settings_run, HOLD_CYCLES);
    $display("results checked %0d: %0d payload beats, %0d frames accepted, %0d dropped",
             sb.checked, sb.payload_beats, sb.frames_accepted, sb.frames_dropped);
    if (sb.mismatches == 0) begin
      $display("** framed_request_receiver: PASSED **");
    end else begin
      $display("** framed_request_receiver: FAILED **");
    end
    $finish;
  end

endmodule
